// ----- hw/rtl/rrts_pkg.sv -----
// Package: shared types and constants of the round robin task scheduler.
package rrts_pkg;

  localparam int TASK_W  = 4;
  localparam int SLICE_W = 8;
  localparam int KIND_W  = 3;
  localparam int POL_W   = 2;
  localparam int QLEN_W  = 5;

  localparam logic [SLICE_W-1:0] SLICE_RESET = 8'd10;

  localparam logic [POL_W-1:0] POLICY_NORMAL = 2'd0;
  localparam logic [POL_W-1:0] POLICY_RR     = 2'd3;

  typedef enum logic [KIND_W-1:0] {
    KIND_ENQUEUE = 3'd0,
    KIND_DEQUEUE = 3'd1,
    KIND_YIELD   = 3'd2,
    KIND_TICK    = 3'd3,
    KIND_PICK    = 3'd4,
    KIND_PREEMPT = 3'd5
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SLICE,
    ST_PICK,
    ST_FINISH
  } state_t;

endpackage

// ----- hw/rtl/round_robin_task_scheduler.sv -----
// Top level: round robin ready queue with per-task time slices.
//
// Input channel (in_valid / in_stall) carries one command item: enqueue,
// dequeue, yield, tick, pick or preempt check, with a task number and the
// running task's class. Each item gives exactly one result item on the
// output channel (out_valid / out_stall).
// Configuration: cfg_valid / cfg_ready writes the slice length; cfg_ready
// is always high. Write it only while the block is idle.
// Enqueue, preempt check and untaken commands go straight to the
// result; pick reads the head slot, a tick reads and rewrites the
// running task's slice counter, and dequeue, yield and a tick that
// expires on a queued task scan the queue. The queue slot memory is
// scanned one slot per cycle through its single read port. One item
// is in work at a time; in_stall is high until the result is placed
// in the output register, so the next item may be taken while that
// result waits.
// Reset empties the queue and sets every slice counter and the slice
// length to ten. While out_stall is high the result is held and a
// finished item waits for the output register to free.
module round_robin_task_scheduler
  import rrts_pkg::*;
#(
  parameter int MAX_TASKS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [KIND_W-1:0]  in_kind,
  input  logic [TASK_W-1:0]  in_task_id,
  input  logic [POL_W-1:0]   in_current_policy,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [TASK_W-1:0]  out_next_task,
  output logic               out_next_valid,
  output logic               out_need_resched,
  output logic               out_op_error,
  output logic [QLEN_W-1:0]  out_queue_length,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [SLICE_W-1:0] cfg_slice_length
);

  localparam int QI_W  = $clog2(MAX_TASKS);
  localparam int CNT_W = $clog2(MAX_TASKS + 1);
  localparam logic [31:0] MAX_U = MAX_TASKS;
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_TASKS);

  state_t state_r, state_nxt;

  logic [TASK_W-1:0]    task_r, task_nxt;
  logic                 move_r, move_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic [MAX_TASKS-1:0] flags_r, flags_nxt;
  logic [MAX_TASKS-1:0] slice_vld_r, slice_vld_nxt;
  logic [SLICE_W-1:0]   slice_length_r, slice_length_nxt;
  logic [CNT_W-1:0]     scan_rd_r, scan_rd_nxt;
  logic                 pend_r, pend_nxt;
  logic                 found_r, found_nxt;

  logic [TASK_W-1:0]    res_task_r, res_task_nxt;
  logic                 res_valid_r, res_valid_nxt;
  logic                 res_resched_r, res_resched_nxt;
  logic                 res_err_r, res_err_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic [TASK_W-1:0]    out_task_r, out_task_nxt;
  logic                 out_nvalid_r, out_nvalid_nxt;
  logic                 out_resched_r, out_resched_nxt;
  logic                 out_err_r, out_err_nxt;
  logic [QLEN_W-1:0]    out_len_r, out_len_nxt;

  logic                 slot_we;
  logic [QI_W-1:0]      slot_wa;
  logic [TASK_W-1:0]    slot_wd;
  logic [QI_W-1:0]      slot_ra;
  logic [TASK_W-1:0]    slot_rd;

  logic                 slice_we;
  logic [SLICE_W-1:0]   slice_wd;
  logic [SLICE_W-1:0]   slice_rd;

  logic [TASK_W-1:0]    cur_task;
  logic [QI_W-1:0]      tidx;
  logic                 task_ok;
  logic                 flag_hit;
  logic [SLICE_W-1:0]   slice_cur;
  logic [SLICE_W-1:0]   slice_dec;
  logic                 slice_expired;
  logic                 issue_rd;
  logic                 scan_done;
  logic                 out_free;
  kind_t                kind_in;

  rrts_ram #(.WIDTH(TASK_W), .DEPTH(MAX_TASKS)) u_slot_ram (
    .clk     (clk),
    .wr_en   (slot_we),
    .wr_addr (slot_wa),
    .wr_data (slot_wd),
    .rd_addr (slot_ra),
    .rd_data (slot_rd)
  );

  rrts_ram #(.WIDTH(SLICE_W), .DEPTH(MAX_TASKS)) u_slice_ram (
    .clk     (clk),
    .wr_en   (slice_we),
    .wr_addr (tidx),
    .wr_data (slice_wd),
    .rd_addr (tidx),
    .rd_data (slice_rd)
  );

  assign kind_in       = kind_t'(in_kind);
  assign cur_task      = (state_r == ST_IDLE) ? in_task_id : task_r;
  assign tidx          = QI_W'(cur_task);
  assign task_ok       = {{(32-TASK_W){1'b0}}, cur_task} < MAX_U;
  assign flag_hit      = task_ok && flags_r[tidx];
  assign slice_cur     = slice_vld_r[tidx] ? slice_rd : SLICE_RESET;
  assign slice_dec     = slice_cur - 8'd1;
  assign slice_expired = (slice_dec == '0);
  assign issue_rd      = scan_rd_r < count_r;
  assign scan_done     = !issue_rd && !pend_r;
  assign out_free      = !out_valid_r || !out_stall;

  assign in_stall  = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;

  assign out_valid        = out_valid_r;
  assign out_next_task    = out_task_r;
  assign out_next_valid   = out_nvalid_r;
  assign out_need_resched = out_resched_r;
  assign out_op_error     = out_err_r;
  assign out_queue_length = out_len_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          case (kind_in)
            KIND_DEQUEUE, KIND_YIELD: begin
              state_nxt = flag_hit ? ST_SCAN : ST_FINISH;
            end
            KIND_TICK: begin
              state_nxt = (in_current_policy == POLICY_RR && task_ok) ? ST_SLICE : ST_FINISH;
            end
            KIND_PICK: begin
              state_nxt = (count_r != '0) ? ST_PICK : ST_FINISH;
            end
            default: begin
              state_nxt = ST_FINISH;
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (scan_done) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_SLICE: begin
        state_nxt = (slice_expired && flag_hit) ? ST_SCAN : ST_FINISH;
      end
      ST_PICK: begin
        state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // datapath and memory control
  always_comb begin
    task_nxt         = task_r;
    move_nxt         = move_r;
    count_nxt        = count_r;
    flags_nxt        = flags_r;
    slice_vld_nxt    = slice_vld_r;
    slice_length_nxt = cfg_valid ? cfg_slice_length : slice_length_r;
    scan_rd_nxt      = scan_rd_r;
    pend_nxt         = pend_r;
    found_nxt        = found_r;
    res_task_nxt     = res_task_r;
    res_valid_nxt    = res_valid_r;
    res_resched_nxt  = res_resched_r;
    res_err_nxt      = res_err_r;
    out_valid_nxt    = out_valid_r && out_stall;
    out_task_nxt     = out_task_r;
    out_nvalid_nxt   = out_nvalid_r;
    out_resched_nxt  = out_resched_r;
    out_err_nxt      = out_err_r;
    out_len_nxt      = out_len_r;
    slot_we          = 1'b0;
    slot_wa          = '0;
    slot_wd          = cur_task;
    slot_ra          = '0;
    slice_we         = 1'b0;
    slice_wd         = slice_dec;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          task_nxt        = in_task_id;
          res_task_nxt    = '0;
          res_valid_nxt   = 1'b0;
          res_resched_nxt = 1'b0;
          res_err_nxt     = 1'b0;
          move_nxt        = (kind_in != KIND_DEQUEUE);
          scan_rd_nxt     = '0;
          pend_nxt        = 1'b0;
          found_nxt       = 1'b0;
          case (kind_in)
            KIND_ENQUEUE: begin
              if (!task_ok || flags_r[tidx] || count_r >= CNT_MAX) begin
                res_err_nxt = 1'b1;
              end else begin
                slot_we         = 1'b1;
                slot_wa         = QI_W'(count_r);
                count_nxt       = count_r + 1'b1;
                flags_nxt[tidx] = 1'b1;
              end
            end
            KIND_DEQUEUE: begin
              if (!flag_hit) begin
                res_err_nxt = 1'b1;
              end else begin
                flags_nxt[tidx] = 1'b0;
              end
            end
            KIND_PREEMPT: begin
              res_resched_nxt = (in_current_policy == POLICY_NORMAL);
            end
            default: begin
            end
          endcase
        end
      end
      ST_SCAN: begin
        slot_ra = QI_W'(scan_rd_r);
        if (issue_rd) begin
          scan_rd_nxt = scan_rd_r + 1'b1;
          pend_nxt    = 1'b1;
        end else begin
          pend_nxt = 1'b0;
        end
        if (pend_r) begin
          if (found_r) begin
            // close the gap: slot read at scan_rd-1 goes one place down
            slot_we = 1'b1;
            slot_wa = QI_W'(scan_rd_r - CNT_W'(2));
            slot_wd = slot_rd;
          end else if (slot_rd == task_r) begin
            found_nxt = 1'b1;
          end
        end
        if (scan_done) begin
          if (move_r) begin
            slot_we = 1'b1;
            slot_wa = QI_W'(count_r - 1'b1);
            slot_wd = task_r;
          end else begin
            count_nxt = count_r - 1'b1;
          end
        end
      end
      ST_SLICE: begin
        slice_we            = 1'b1;
        slice_vld_nxt[tidx] = 1'b1;
        move_nxt            = 1'b1;
        if (slice_expired) begin
          slice_wd        = slice_length_r;
          res_resched_nxt = 1'b1;
        end
      end
      ST_PICK: begin
        res_task_nxt  = slot_rd;
        res_valid_nxt = 1'b1;
      end
      ST_FINISH: begin
        if (out_free) begin
          out_valid_nxt   = 1'b1;
          out_task_nxt    = res_task_r;
          out_nvalid_nxt  = res_valid_r;
          out_resched_nxt = res_resched_r;
          out_err_nxt     = res_err_r;
          out_len_nxt     = QLEN_W'(count_r);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      count_r        <= '0;
      flags_r        <= '0;
      slice_vld_r    <= '0;
      slice_length_r <= SLICE_RESET;
      scan_rd_r      <= '0;
      pend_r         <= 1'b0;
      found_r        <= 1'b0;
      move_r         <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      count_r        <= count_nxt;
      flags_r        <= flags_nxt;
      slice_vld_r    <= slice_vld_nxt;
      slice_length_r <= slice_length_nxt;
      scan_rd_r      <= scan_rd_nxt;
      pend_r         <= pend_nxt;
      found_r        <= found_nxt;
      move_r         <= move_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    task_r        <= task_nxt;
    res_task_r    <= res_task_nxt;
    res_valid_r   <= res_valid_nxt;
    res_resched_r <= res_resched_nxt;
    res_err_r     <= res_err_nxt;
    out_task_r    <= out_task_nxt;
    out_nvalid_r  <= out_nvalid_nxt;
    out_resched_r <= out_resched_nxt;
    out_err_r     <= out_err_nxt;
    out_len_r     <= out_len_nxt;
  end

endmodule

// ----- hw/rtl/rrts_ram.sv -----
// Generic simple dual-port RAM with registered read.
module rrts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule
